// ===== rtl/nfpa_pkg.sv =====
// ----------------------------------------------------------------------------
// nfpa_pkg
// Shared widths, codes and types of the next-fit page pool allocator.
// ----------------------------------------------------------------------------
package nfpa_pkg;

  localparam int PAGE_W     = 8;   // page index
  localparam int CNT_W      = 9;   // page count, holds 256
  localparam int ADDR_W     = 48;  // page address
  localparam int PSIZE_W    = 25;  // page size
  localparam int PROD_W     = PAGE_W + PSIZE_W;
  localparam int WORD_W     = 32;  // pages per bitmap word
  localparam int BIT_W      = 5;   // bit position inside a word
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;
  localparam int OUT_DATA_W = 64;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE    = 2'd2;

  // operation codes
  localparam logic FUNC_GET     = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD,
    ST_SCAN,
    ST_MUL,
    ST_ADD,
    ST_RCMP,
    ST_RRD,
    ST_RWB,
    ST_FIN
  } nfpa_state_t;

  typedef struct packed {
    logic             go;
    logic [CNT_W-1:0] num;
    logic [CNT_W-1:0] den;
  } nfpa_mod_req_t;

  typedef struct packed {
    logic              done;
    logic [PAGE_W-1:0] rem;
  } nfpa_mod_rsp_t;

endpackage

// ===== rtl/nfpa_ram.sv =====
// ----------------------------------------------------------------------------
// nfpa_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module nfpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/nfpa_word_find.sv =====
// ----------------------------------------------------------------------------
// nfpa_word_find
// Finds the lowest set bit of a bitmap word of candidate pages.
// ----------------------------------------------------------------------------
module nfpa_word_find (
  input  logic [nfpa_pkg::WORD_W-1:0] cand,
  output logic                        found,
  output logic [nfpa_pkg::BIT_W-1:0]  pos
);

  always_comb begin
    pos = '0;
    // walk downward so the lowest set bit wins
    for (int i = nfpa_pkg::WORD_W - 1; i >= 0; i--) begin
      if (cand[i]) begin
        pos = nfpa_pkg::BIT_W'(i);
      end
    end
    found = |cand;
  end

endmodule

// ===== rtl/nfpa_start_mod.sv =====
// ----------------------------------------------------------------------------
// nfpa_start_mod
// Scan start index: (last index + 1) mod page count, one quotient bit a cycle.
// Answers in the cycle after go when the value is already below the count.
// ----------------------------------------------------------------------------
module nfpa_start_mod (
  input  logic                    clk,
  input  logic                    rst_n,
  input  nfpa_pkg::nfpa_mod_req_t req,
  output nfpa_pkg::nfpa_mod_rsp_t rsp
);

  localparam int STEP_W = $clog2(nfpa_pkg::CNT_W + 1);

  logic                        busy_r;
  logic                        done_r;
  logic [STEP_W-1:0]           step_r;
  logic [nfpa_pkg::CNT_W-1:0]  num_r;
  logic [nfpa_pkg::CNT_W-1:0]  den_r;
  logic [nfpa_pkg::CNT_W-1:0]  rem_r;
  logic [nfpa_pkg::CNT_W:0]    trial;
  logic [nfpa_pkg::CNT_W-1:0]  rem_nxt;

  always_comb begin
    trial = {rem_r, num_r[nfpa_pkg::CNT_W-1]};
    if (trial >= {1'b0, den_r}) begin
      rem_nxt = nfpa_pkg::CNT_W'(trial - {1'b0, den_r});
    end else begin
      rem_nxt = nfpa_pkg::CNT_W'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        if (req.num < req.den) begin
          rem_r  <= req.num;
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
          rem_r  <= '0;
          num_r  <= req.num;
          den_r  <= req.den;
          step_r <= STEP_W'(nfpa_pkg::CNT_W);
        end
      end else if (busy_r) begin
        rem_r  <= rem_nxt;
        num_r  <= num_r << 1;
        step_r <= step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r[nfpa_pkg::PAGE_W-1:0];

endmodule

// ===== rtl/next_fit_page_pool_allocator.sv =====
// ----------------------------------------------------------------------------
// next_fit_page_pool_allocator
// Next-fit page allocator over a used bitmap held in RAM, 32 pages a word.
//
//   channel  direction  payload
//   in_      slave      tuser: func; tdata: page_address
//   out_     master     tdata: ok, granted_address, page_number
//   cfg_     slave      index 0 page_count, 1 base_address, 2 page_size
//
// Scan start is last index + 1 if below the page count, else (wrap to page
// zero, or a lowered count) nfpa_start_mod works out the remainder.
// A get then streams one bitmap word per cycle (at most (count-1)/32 + 2
// reads, each judged in the next cycle), then the MUL, ADD and FIN states form
// the address and result. A release compares one page address per cycle, up to
// page_count addresses, then a read-modify-write of the bitmap word. One request at a time.
// Reset clears the per-word valid bits at once; there is no clearing pass.
// A finished result waits in the output register while the next request
// is taken; a new result is held until that register is free.
// ----------------------------------------------------------------------------
module next_fit_page_pool_allocator #(
  parameter int MAX_PAGES = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [nfpa_pkg::ADDR_W-1:0]       in_tdata,   // [47:0] page_address
  input  logic                              in_tuser,   // [0] func
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [nfpa_pkg::OUT_DATA_W-1:0]   out_tdata,  // [0] ok, [48:1] granted_address,
                                                        // [56:49] page_number, [63:57] zero
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [nfpa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [nfpa_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int PAGE_LIMIT = (MAX_PAGES < 256) ? MAX_PAGES : 256;
  localparam int NWORDS     = (PAGE_LIMIT + nfpa_pkg::WORD_W - 1) / nfpa_pkg::WORD_W;
  localparam int WA_W       = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam logic [nfpa_pkg::CNT_W-1:0]  LIMIT      = nfpa_pkg::CNT_W'(PAGE_LIMIT);
  localparam logic [nfpa_pkg::PAGE_W-1:0] RESET_LAST = nfpa_pkg::PAGE_W'(PAGE_LIMIT - 1);

  // configuration
  logic [nfpa_pkg::CNT_W-1:0]   page_count_r;
  logic [nfpa_pkg::ADDR_W-1:0]  base_r;
  logic [nfpa_pkg::PSIZE_W-1:0] psize_r;
  logic [nfpa_pkg::CNT_W-1:0]   n_eff;

  // allocator state
  nfpa_pkg::nfpa_state_t        state_r, state_nxt;
  logic [nfpa_pkg::PAGE_W-1:0]  last_gr_r;
  logic [nfpa_pkg::PAGE_W-1:0]  last_rel_r;
  logic [NWORDS-1:0]            valid_r;
  logic                         func_r;
  logic [nfpa_pkg::ADDR_W-1:0]  addr_r;
  logic [nfpa_pkg::PAGE_W-1:0]  start_r;
  logic [nfpa_pkg::PAGE_W-1:0]  sel_idx_r;
  logic [nfpa_pkg::PROD_W-1:0]  prod_r;
  logic [nfpa_pkg::ADDR_W-1:0]  sum_r;
  logic [nfpa_pkg::CNT_W-1:0]   cnt_r;

  // bitmap scan pipeline: issue stage and data stage
  logic [WA_W-1:0]              iss_w_r;
  logic                         iss_ph_r;
  logic                         iss_end_r;
  logic                         d_v_r;
  logic [WA_W-1:0]              d_w_r;
  logic                         d_ph_r;
  logic                         d_last_r;

  // result
  logic                         res_ok_r;
  logic [nfpa_pkg::ADDR_W-1:0]  res_addr_r;
  logic [nfpa_pkg::PAGE_W-1:0]  res_page_r;
  logic                         out_valid_r;
  logic                         out_ok_r;
  logic [nfpa_pkg::ADDR_W-1:0]  out_addr_r;
  logic [nfpa_pkg::PAGE_W-1:0]  out_page_r;

  // combinational
  logic                         in_xfer;
  logic                         out_free;
  logic [WA_W-1:0]              w0;
  logic [WA_W-1:0]              wl;
  logic [WA_W-1:0]              rel_w;
  logic                         iss_last;
  logic [WA_W-1:0]              word_w;
  logic [nfpa_pkg::WORD_W-1:0]  ram_rdata;
  logic [nfpa_pkg::WORD_W-1:0]  word_v;
  logic [nfpa_pkg::WORD_W-1:0]  mask;
  logic [nfpa_pkg::WORD_W-1:0]  cand;
  logic                         hit_found;
  logic                         hit;
  logic [nfpa_pkg::BIT_W-1:0]   hit_pos;
  logic [nfpa_pkg::PAGE_W-1:0]  hit_idx;
  logic [nfpa_pkg::CNT_W-1:0]   bit_idx;
  logic [nfpa_pkg::ADDR_W-1:0]  add_sum;
  logic [nfpa_pkg::CNT_W-1:0]   next_idx;
  logic                         ram_we;
  logic [WA_W-1:0]              ram_waddr;
  logic [nfpa_pkg::WORD_W-1:0]  ram_wdata;
  logic [WA_W-1:0]              ram_raddr;
  nfpa_pkg::nfpa_mod_req_t      mod_req;
  nfpa_pkg::nfpa_mod_rsp_t      mod_rsp;

  // ---------------------------------------------------------------- config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_count_r <= nfpa_pkg::CNT_W'(256);
      base_r       <= '0;
      psize_r      <= nfpa_pkg::PSIZE_W'(4096);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        nfpa_pkg::CFG_PAGE_COUNT:   page_count_r <= cfg_data[nfpa_pkg::CNT_W-1:0];
        nfpa_pkg::CFG_BASE_ADDRESS: base_r       <= cfg_data[nfpa_pkg::ADDR_W-1:0];
        nfpa_pkg::CFG_PAGE_SIZE:    psize_r      <= cfg_data[nfpa_pkg::PSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (page_count_r == '0) begin
      n_eff = nfpa_pkg::CNT_W'(1);
    end else if (page_count_r > LIMIT) begin
      n_eff = LIMIT;
    end else begin
      n_eff = page_count_r;
    end
  end

  // ---------------------------------------------------------------- units
  nfpa_start_mod u_start_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .rsp   (mod_rsp)
  );

  nfpa_ram #(
    .WIDTH (nfpa_pkg::WORD_W),
    .DEPTH (NWORDS)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  nfpa_word_find u_word_find (
    .cand  (cand),
    .found (hit_found),
    .pos   (hit_pos)
  );

  // ---------------------------------------------------------------- datapath
  assign in_tready = (state_r == nfpa_pkg::ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign w0       = WA_W'(start_r >> nfpa_pkg::BIT_W);
  assign wl       = WA_W'((n_eff - 1'b1) >> nfpa_pkg::BIT_W);
  assign rel_w    = WA_W'(sel_idx_r >> nfpa_pkg::BIT_W);
  assign iss_last = iss_ph_r && (iss_w_r == w0);
  assign word_w   = (state_r == nfpa_pkg::ST_RWB) ? rel_w : d_w_r;
  assign word_v   = valid_r[word_w] ? ram_rdata : '0;
  assign add_sum  = base_r + nfpa_pkg::ADDR_W'(prod_r);
  assign next_idx = nfpa_pkg::CNT_W'(sel_idx_r) + 1'b1;

  // first pass covers start .. count-1, second pass covers 0 .. start-1
  always_comb begin
    for (int b = 0; b < nfpa_pkg::WORD_W; b++) begin
      bit_idx = (nfpa_pkg::CNT_W'(d_w_r) << nfpa_pkg::BIT_W) | nfpa_pkg::CNT_W'(b);
      if (d_ph_r) begin
        mask[b] = bit_idx < {1'b0, start_r};
      end else begin
        mask[b] = (bit_idx >= {1'b0, start_r}) && (bit_idx < n_eff);
      end
    end
  end

  assign cand    = ~word_v & mask & {nfpa_pkg::WORD_W{d_v_r}};
  assign hit     = (state_r == nfpa_pkg::ST_SCAN) && hit_found;
  assign hit_idx = nfpa_pkg::PAGE_W'((nfpa_pkg::CNT_W'(d_w_r) << nfpa_pkg::BIT_W)
                   | nfpa_pkg::CNT_W'(hit_pos));

  // requests run one at a time, so a bitmap write never meets a pending read
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = d_w_r;
    ram_wdata = word_v | (nfpa_pkg::WORD_W'(1) << hit_pos);
    ram_raddr = iss_w_r;
    if (state_r == nfpa_pkg::ST_SCAN) begin
      ram_we = hit;
    end else if (state_r == nfpa_pkg::ST_RRD) begin
      ram_raddr = rel_w;
    end else if (state_r == nfpa_pkg::ST_RWB) begin
      ram_we    = 1'b1;
      ram_waddr = rel_w;
      ram_wdata = word_v & ~(nfpa_pkg::WORD_W'(1) << sel_idx_r[nfpa_pkg::BIT_W-1:0]);
    end
  end

  always_comb begin
    mod_req.go  = in_xfer;
    mod_req.den = n_eff;
    if (in_tuser == nfpa_pkg::FUNC_RELEASE) begin
      mod_req.num = nfpa_pkg::CNT_W'(last_rel_r) + 1'b1;
    end else begin
      mod_req.num = nfpa_pkg::CNT_W'(last_gr_r) + 1'b1;
    end
  end

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nfpa_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      nfpa_pkg::ST_IDLE: begin
        if (in_xfer) state_nxt = nfpa_pkg::ST_MOD;
      end
      nfpa_pkg::ST_MOD: begin
        if (mod_rsp.done) begin
          state_nxt = (func_r == nfpa_pkg::FUNC_RELEASE) ? nfpa_pkg::ST_MUL
                                                         : nfpa_pkg::ST_SCAN;
        end
      end
      nfpa_pkg::ST_SCAN: begin
        if (hit) begin
          state_nxt = nfpa_pkg::ST_MUL;
        end else if (d_v_r && d_last_r) begin
          state_nxt = nfpa_pkg::ST_FIN;
        end
      end
      nfpa_pkg::ST_MUL: state_nxt = nfpa_pkg::ST_ADD;
      nfpa_pkg::ST_ADD: begin
        state_nxt = (func_r == nfpa_pkg::FUNC_RELEASE) ? nfpa_pkg::ST_RCMP
                                                       : nfpa_pkg::ST_FIN;
      end
      nfpa_pkg::ST_RCMP: begin
        if (sum_r == addr_r) begin
          state_nxt = nfpa_pkg::ST_RRD;
        end else if (cnt_r == n_eff - 1'b1) begin
          state_nxt = nfpa_pkg::ST_FIN;
        end
      end
      nfpa_pkg::ST_RRD: state_nxt = nfpa_pkg::ST_RWB;
      nfpa_pkg::ST_RWB: state_nxt = nfpa_pkg::ST_FIN;
      nfpa_pkg::ST_FIN: begin
        if (out_free) state_nxt = nfpa_pkg::ST_IDLE;
      end
      default: state_nxt = nfpa_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_gr_r   <= RESET_LAST;
      last_rel_r  <= RESET_LAST;
      valid_r     <= '0;
      d_v_r       <= 1'b0;
      iss_end_r   <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (ram_we) begin
        valid_r[ram_waddr] <= 1'b1;
      end
      if (state_r == nfpa_pkg::ST_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        nfpa_pkg::ST_IDLE: begin
          if (in_xfer) begin
            func_r <= in_tuser;
            addr_r <= in_tdata;
          end
        end
        nfpa_pkg::ST_MOD: begin
          d_v_r <= 1'b0;
          if (mod_rsp.done) begin
            start_r   <= mod_rsp.rem;
            sel_idx_r <= mod_rsp.rem;
            iss_w_r   <= WA_W'(mod_rsp.rem >> nfpa_pkg::BIT_W);
            iss_ph_r  <= 1'b0;
            iss_end_r <= 1'b0;
          end
        end
        nfpa_pkg::ST_SCAN: begin
          // stream one word read per cycle, evaluate the word read before
          if (!iss_end_r && !hit) begin
            d_v_r    <= 1'b1;
            d_w_r    <= iss_w_r;
            d_ph_r   <= iss_ph_r;
            d_last_r <= iss_last;
            if (iss_last) begin
              iss_end_r <= 1'b1;
            end else if (!iss_ph_r && iss_w_r == wl) begin
              iss_ph_r <= 1'b1;
              iss_w_r  <= '0;
            end else begin
              iss_w_r <= iss_w_r + 1'b1;
            end
          end else begin
            d_v_r <= 1'b0;
          end
          if (hit) begin
            last_gr_r <= hit_idx;
            sel_idx_r <= hit_idx;
            iss_end_r <= 1'b1;
          end else if (d_v_r && d_last_r) begin
            res_ok_r   <= 1'b0;
            res_addr_r <= '0;
            res_page_r <= '0;
          end
        end
        nfpa_pkg::ST_MUL: begin
          prod_r <= sel_idx_r * psize_r;
        end
        nfpa_pkg::ST_ADD: begin
          sum_r      <= add_sum;
          cnt_r      <= '0;
          res_ok_r   <= 1'b1;
          res_addr_r <= add_sum;
          res_page_r <= sel_idx_r;
        end
        nfpa_pkg::ST_RCMP: begin
          if (sum_r != addr_r) begin
            cnt_r <= cnt_r + 1'b1;
            if (next_idx == n_eff) begin
              sel_idx_r <= '0;
              sum_r     <= base_r;
            end else begin
              sel_idx_r <= nfpa_pkg::PAGE_W'(next_idx);
              sum_r     <= sum_r + nfpa_pkg::ADDR_W'(psize_r);
            end
            if (cnt_r == n_eff - 1'b1) begin
              res_ok_r   <= 1'b0;
              res_addr_r <= '0;
              res_page_r <= '0;
            end
          end
        end
        nfpa_pkg::ST_RRD: ;
        nfpa_pkg::ST_RWB: begin
          last_rel_r <= sel_idx_r;
          res_ok_r   <= 1'b1;
          res_addr_r <= '0;
          res_page_r <= sel_idx_r;
        end
        nfpa_pkg::ST_FIN: begin
          if (out_free) begin
            out_ok_r   <= res_ok_r;
            out_addr_r <= res_addr_r;
            out_page_r <= res_page_r;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(nfpa_pkg::OUT_DATA_W - 1 - nfpa_pkg::ADDR_W - nfpa_pkg::PAGE_W){1'b0}},
                       out_page_r, out_addr_r, out_ok_r};

  // ---------------------------------------------------------------- checks
  a_bitmap_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == nfpa_pkg::ST_SCAN || state_r == nfpa_pkg::ST_RWB))
    else $error("bitmap written outside scan or release write-back");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ok_r) |-> (out_addr_r == '0 && out_page_r == '0))
    else $error("failed result carries nonzero address or page");

  a_page_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ok_r) |-> (nfpa_pkg::CNT_W'(out_page_r) < n_eff))
    else $error("result page beyond the pool");

  a_mod_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    mod_rsp.done |-> state_r == nfpa_pkg::ST_MOD)
    else $error("scan start delivered outside start phase");

endmodule
